/* rtl/rdf_pkg.sv */
package rdf_pkg;

  localparam int STATIONS = 16;
  localparam int QUEUES   = 4;
  localparam int TIDS     = 8;

  localparam int SLOTS   = TIDS + 1;
  localparam int ENTRIES = STATIONS * QUEUES * SLOTS;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W  = $clog2(SLOTS);

  localparam int SEQ_W = 16;
  localparam int SUB_W = 7;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 8;

  // Frame control decoding, host order.
  localparam logic [15:0] FC_TYPE_MASK         = 16'h000C;
  localparam logic [15:0] FC_TYPE_CTL          = 16'h0004;
  localparam logic [15:0] FC_TYPE_DATA         = 16'h0008;
  localparam logic [15:0] FC_TYPE_SUBTYPE_MASK = 16'h00FC;
  localparam logic [15:0] FC_NULLFUNC          = 16'h0048;
  localparam logic [15:0] FC_QOS_NULLFUNC      = 16'h00C8;
  localparam logic [15:0] FC_QOS_BIT           = 16'h0080;
  localparam int          FC_RETRY_BIT         = 11;

  localparam logic [SEQ_W-1:0] SEQ_RESET = '1;
  localparam logic [SUB_W-1:0] SUB_RESET = '0;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_DROP,
    KIND_CHECK
  } rdf_kind_e;

  typedef enum logic {
    CLR_SWEEP,
    CLR_DONE
  } rdf_clr_state_e;

  typedef struct packed {
    logic        station_valid;
    logic [3:0]  station_index;
    logic [1:0]  queue_index;
    logic [15:0] frame_ctl;
    logic        addr1_multicast;
    logic [15:0] seq_control;
    logic [3:0]  qos_tid;
    logic [6:0]  subframe_index;
    logic        amsdu_flag;
  } rdf_in_t;

  typedef struct packed {
    rdf_kind_e        kind;
    logic [IDX_W-1:0] idx;
    logic [SEQ_W-1:0] seq;
    logic [SUB_W-1:0] sub;
    logic             retry;
  } rdf_desc_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [SUB_W-1:0] sub;
  } rdf_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } rdf_rd_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    rdf_entry_t       entry;
  } rdf_wr_req_t;

endpackage

/* rtl/rdf_decode.sv */
module rdf_decode (
  input  rdf_pkg::rdf_in_t   item_i,
  output rdf_pkg::rdf_desc_t desc_o
);
  import rdf_pkg::*;

  logic              in_range;
  logic              exempt;
  logic              qos_data;
  logic              tid_bad;
  logic              sub_bad;
  logic [SLOT_W-1:0] slot;
  logic [15:0]       fc;

  assign fc = item_i.frame_ctl;

  assign in_range = item_i.station_valid &&
                    (32'(item_i.station_index) < 32'(STATIONS)) &&
                    (32'(item_i.queue_index) < 32'(QUEUES));

  assign exempt = ((fc & FC_TYPE_MASK) == FC_TYPE_CTL) ||
                  ((fc & FC_TYPE_SUBTYPE_MASK) == FC_NULLFUNC) ||
                  ((fc & FC_TYPE_SUBTYPE_MASK) == FC_QOS_NULLFUNC) ||
                  item_i.addr1_multicast;

  assign qos_data = ((fc & (FC_TYPE_MASK | FC_QOS_BIT)) == (FC_TYPE_DATA | FC_QOS_BIT));
  assign tid_bad  = qos_data && (32'(item_i.qos_tid) >= 32'(TIDS));
  assign sub_bad  = (item_i.subframe_index != '0) && !item_i.amsdu_flag;

  // Non-QoS frames share the slot just past the TID slots.
  assign slot = qos_data ? SLOT_W'(item_i.qos_tid) : SLOT_W'(TIDS);

  always_comb begin
    if (!in_range || exempt) begin
      desc_o.kind = KIND_PASS;
    end else if (tid_bad || sub_bad) begin
      desc_o.kind = KIND_DROP;
    end else begin
      desc_o.kind = KIND_CHECK;
    end
    desc_o.idx   = (IDX_W'(item_i.station_index) * IDX_W'(QUEUES) +
                    IDX_W'(item_i.queue_index)) * IDX_W'(SLOTS) + IDX_W'(slot);
    desc_o.seq   = item_i.seq_control;
    desc_o.sub   = item_i.subframe_index;
    desc_o.retry = fc[FC_RETRY_BIT];
  end

endmodule

/* rtl/rdf_table.sv */
module rdf_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rdf_pkg::rdf_rd_req_t rd_req_i,
  input  rdf_pkg::rdf_wr_req_t wr_req_i,
  output rdf_pkg::rdf_entry_t  rd_entry_o,
  output logic                 ready_o
);
  import rdf_pkg::*;

  rdf_entry_t       mem [ENTRIES];
  rdf_entry_t       rd_data_q;
  rdf_entry_t       fwd_data_q;
  logic             fwd_hit_q;
  rdf_clr_state_e   state_q, state_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_last;

  logic             we;
  logic [IDX_W-1:0] waddr;
  rdf_entry_t       wdata;

  assign clr_last = (32'(clr_cnt_q) == 32'(ENTRIES - 1));

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      CLR_SWEEP: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_last) begin
          state_d = CLR_DONE;
        end
      end
      CLR_DONE: begin
        clr_cnt_d = clr_cnt_q;
      end
      default: begin
        state_d = CLR_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CLR_SWEEP;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign ready_o = (state_q == CLR_DONE);

  always_comb begin
    if (state_q == CLR_SWEEP) begin
      we        = 1'b1;
      waddr     = clr_cnt_q;
      wdata.seq = SEQ_RESET;
      wdata.sub = SUB_RESET;
    end else begin
      we    = wr_req_i.en;
      waddr = wr_req_i.idx;
      wdata = wr_req_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_req_i.en) begin
      rd_data_q <= mem[rd_req_i.idx];
    end
  end

  // A read that meets a write to the same entry in one cycle sees the old
  // contents, so the written entry is kept and substituted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_req_i.en) begin
      fwd_hit_q <= we && (waddr == rd_req_i.idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      fwd_data_q <= wdata;
    end
  end

  assign rd_entry_o = fwd_hit_q ? fwd_data_q : rd_data_q;

endmodule

/* rtl/rdf_check.sv */
module rdf_check (
  input  rdf_pkg::rdf_desc_t  desc_i,
  input  rdf_pkg::rdf_entry_t entry_i,
  output logic                drop_o,
  output logic                allow_same_pn_o,
  output logic                dup_validated_o,
  output rdf_pkg::rdf_wr_req_t wr_req_o
);
  import rdf_pkg::*;

  logic match;
  logic dup;

  assign match = (entry_i.seq == desc_i.seq);
  assign dup   = desc_i.retry && match && (entry_i.sub >= desc_i.sub);

  always_comb begin
    drop_o          = 1'b0;
    allow_same_pn_o = 1'b0;
    dup_validated_o = 1'b0;
    case (desc_i.kind)
      KIND_PASS: begin
        drop_o = 1'b0;
      end
      KIND_DROP: begin
        drop_o = 1'b1;
      end
      KIND_CHECK: begin
        if (dup) begin
          drop_o = 1'b1;
        end else begin
          allow_same_pn_o = match && (desc_i.sub > entry_i.sub);
          dup_validated_o = 1'b1;
        end
      end
      default: begin
        drop_o = 1'b0;
      end
    endcase
  end

  assign wr_req_o.en        = (desc_i.kind == KIND_CHECK) && !dup;
  assign wr_req_o.idx       = desc_i.idx;
  assign wr_req_o.entry.seq = desc_i.seq;
  assign wr_req_o.entry.sub = desc_i.sub;

endmodule

/* rtl/wlan_rx_duplicate_filter_core.sv */
// Channel   | Direction | Signals                     | Content
// s_axis    | in        | tvalid, tready, tdata[55:0] | one received frame descriptor
// m_axis    | out       | tvalid, tready, tdata[7:0]  | one filter verdict per descriptor
//
// One descriptor is taken per cycle unless the reset sweep or a held verdict stalls s_axis;
// its verdict moves from the lookup stage into the output register and then leaves on m_axis.
// The rate is set by one read-modify-write of the duplicate table per descriptor, with the
// written entry forwarded to a read of the same entry.
// After reset the table is swept to its reset contents with s_axis_tready low.
// A verdict that is not taken stalls the lookup stage and s_axis_tready falls.
module wlan_rx_duplicate_filter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // station_valid, station_index, queue_index, frame_ctl, addr1_multicast,
  // seq_control, qos_tid, subframe_index, amsdu_flag, zero fill
  input  logic [rdf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // drop, allow_same_pn, dup_validated, zero fill
  output logic [rdf_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import rdf_pkg::*;

  rdf_in_t     item;
  rdf_desc_t   desc;
  rdf_desc_t   s1_desc_q;
  logic        s1_valid_q;
  rdf_entry_t  entry;
  rdf_rd_req_t rd_req;
  rdf_wr_req_t wr_chk;
  rdf_wr_req_t wr_req;
  logic        table_ready;
  logic        in_xfer;
  logic        out_free;
  logic        s1_adv;
  logic        drop, allow_same_pn, dup_validated;
  logic        m_valid_q;
  logic [2:0]  m_data_q;

  assign item.station_valid   = s_axis_tdata[0];
  assign item.station_index   = s_axis_tdata[4:1];
  assign item.queue_index     = s_axis_tdata[6:5];
  assign item.frame_ctl       = s_axis_tdata[22:7];
  assign item.addr1_multicast = s_axis_tdata[23];
  assign item.seq_control     = s_axis_tdata[39:24];
  assign item.qos_tid         = s_axis_tdata[43:40];
  assign item.subframe_index  = s_axis_tdata[50:44];
  assign item.amsdu_flag      = s_axis_tdata[51];

  rdf_decode u_decode (
    .item_i (item),
    .desc_o (desc)
  );

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = table_ready && (!s1_valid_q || out_free);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign rd_req.en  = in_xfer && (desc.kind == KIND_CHECK);
  assign rd_req.idx = desc.idx;

  assign wr_req.en    = wr_chk.en && s1_adv;
  assign wr_req.idx   = wr_chk.idx;
  assign wr_req.entry = wr_chk.entry;

  rdf_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_req_i   (rd_req),
    .wr_req_i   (wr_req),
    .rd_entry_o (entry),
    .ready_o    (table_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_desc_q <= desc;
    end
  end

  rdf_check u_check (
    .desc_i          (s1_desc_q),
    .entry_i         (entry),
    .drop_o          (drop),
    .allow_same_pn_o (allow_same_pn),
    .dup_validated_o (dup_validated),
    .wr_req_o        (wr_chk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_data_q <= {dup_validated, allow_same_pn, drop};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - 3)'(0), m_data_q};

endmodule

/* rtl/rdf_checker.sv */
module rdf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [rdf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rdf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // A descriptor waiting for its transfer stays on the bus unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("descriptor changed before transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("verdict withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("verdict changed while stalled");

  // A dropped frame never updates the table.
  a_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[2]))
    else $error("drop together with dup_validated");

  // PN reuse is granted only to a frame that passed the check.
  a_pn_validated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[2] && !m_axis_tdata[0])
    else $error("allow_same_pn without validation");

endmodule

bind wlan_rx_duplicate_filter_core rdf_checker u_rdf_checker (.*);

/* tb/wlan_rx_duplicate_filter_core_test.sv */
module wlan_rx_duplicate_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rdf_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_WAIT     = 12;
  localparam int PRINT_CAP    = 50;

  localparam logic [15:0] FC_RETRY         = 16'h1 << FC_RETRY_BIT;
  localparam logic [15:0] FC_QOS_DATA      = FC_TYPE_DATA | FC_QOS_BIT;
  localparam logic [15:0] FC_CTL_ACK       = 16'h00D4;
  localparam logic [15:0] FC_MGMT_AUTH     = 16'h00B0;
  localparam logic [15:0] FC_RESERVED_TYPE = 16'h000C;

  // Bit order matches m_axis_tdata[2:0].
  typedef struct packed {
    logic dup_validated;
    logic allow_same_pn;
    logic drop;
  } verdict_t;

  localparam verdict_t V_PASS = 3'b000;
  localparam verdict_t V_DROP = 3'b001;
  localparam verdict_t V_NEW  = 3'b100;
  localparam verdict_t V_PN   = 3'b110;

  typedef struct packed {
    rdf_in_t  desc;
    logic     typed;
    verdict_t want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow of the duplicate table, one entry per station, queue and slot (TID or non-QoS).
  logic [SEQ_W-1:0] seq_mem [ENTRIES];
  logic [SUB_W-1:0] sub_mem [ENTRIES];

  verdict_t    verdict_q [$];
  dir_row_t    dir_tab [$];
  logic [15:0] seq_pool [4];

  int  errors = 0;
  int  items_sent = 0;
  int  verdicts_seen = 0;
  int  drops_seen = 0;
  int  same_pn_seen = 0;
  int  updates_seen = 0;
  int  idle_cycles = 0;
  bit  src_burst = 1'b0;
  bit  sink_burst = 1'b0;

  wlan_rx_duplicate_filter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [IN_DATA_W-1:0] pack_desc(rdf_in_t f);
    return {4'b0, f.amsdu_flag, f.subframe_index, f.qos_tid, f.seq_control,
            f.addr1_multicast, f.frame_ctl, f.queue_index, f.station_index,
            f.station_valid};
  endfunction

  function automatic int unsigned pick_wait(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Verdict for one descriptor; updates the shadow table like the hardware does.
  function automatic verdict_t filter_frame(rdf_in_t f);
    verdict_t v;
    int       slot;
    int       e;
    logic     hit;
    v = V_PASS;
    if (!f.station_valid || f.station_index >= STATIONS || f.queue_index >= QUEUES)
      return v;
    if ((f.frame_ctl & FC_TYPE_MASK) == FC_TYPE_CTL ||
        (f.frame_ctl & FC_TYPE_SUBTYPE_MASK) == FC_NULLFUNC ||
        (f.frame_ctl & FC_TYPE_SUBTYPE_MASK) == FC_QOS_NULLFUNC ||
        f.addr1_multicast)
      return v;
    if ((f.frame_ctl & (FC_TYPE_MASK | FC_QOS_BIT)) == FC_QOS_DATA) begin
      if (f.qos_tid >= TIDS) begin
        v.drop = 1'b1;
        return v;
      end
      slot = int'(f.qos_tid);
    end else begin
      slot = TIDS;
    end
    if (f.subframe_index != 0 && !f.amsdu_flag) begin
      v.drop = 1'b1;
      return v;
    end
    e = (int'(f.station_index) * QUEUES + int'(f.queue_index)) * SLOTS + slot;
    hit = (seq_mem[e] == f.seq_control);
    if (f.frame_ctl[FC_RETRY_BIT] && hit && sub_mem[e] >= f.subframe_index) begin
      v.drop = 1'b1;
      return v;
    end
    v.allow_same_pn = hit && (f.subframe_index > sub_mem[e]);
    seq_mem[e] = f.seq_control;
    sub_mem[e] = f.subframe_index;
    v.dup_validated = 1'b1;
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (errors < PRINT_CAP)
      $display("ERROR: verdict %0d: %s is %0d, expected %0d", verdicts_seen, what, got, want);
    errors++;
  endtask

  task automatic add_row(logic v, logic [3:0] sta, logic [1:0] q, logic [15:0] fc,
                         logic mc, logic [15:0] seq, logic [3:0] tid, logic [6:0] sub,
                         logic am, logic typed, verdict_t want);
    dir_row_t r;
    r.desc.station_valid   = v;
    r.desc.station_index   = sta;
    r.desc.queue_index     = q;
    r.desc.frame_ctl       = fc;
    r.desc.addr1_multicast = mc;
    r.desc.seq_control     = seq;
    r.desc.qos_tid         = tid;
    r.desc.subframe_index  = sub;
    r.desc.amsdu_flag      = am;
    r.typed = typed;
    r.want  = want;
    dir_tab.push_back(r);
  endtask

  // Holds tvalid through back-to-back transfers; it only falls when a gap is drawn.
  task automatic send_desc(rdf_in_t f, logic typed, verdict_t want);
    int unsigned gap;
    verdict_t    pred;
    gap = pick_wait(src_burst);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_desc(f);
    do @(posedge clk_i); while (!s_axis_tready);
    pred = filter_frame(f);
    verdict_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // One frame exchange, sometimes malformed: an MSDU or A-MSDU, sometimes followed by a
  // retransmission of one of its subframes.
  task automatic send_run();
    rdf_in_t     f;
    int unsigned kind;
    int unsigned extra;
    int          sub;
    int          step;
    bit          broken;
    logic [6:0]  subs [$];
    f = '0;
    f.station_valid = ($urandom_range(0, 15) != 0);
    f.station_index = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 2));
    f.queue_index = 2'($urandom_range(0, 3));
    f.frame_ctl = 16'($urandom);
    kind = $urandom_range(0, 9);
    if (kind < 6)
      f.frame_ctl = (f.frame_ctl & ~(FC_TYPE_MASK | FC_QOS_BIT)) | FC_QOS_DATA;
    else if (kind < 8)
      f.frame_ctl = (f.frame_ctl & ~(FC_TYPE_MASK | FC_QOS_BIT)) | FC_TYPE_DATA;
    else if (kind == 8)
      f.frame_ctl = f.frame_ctl & ~FC_TYPE_MASK;
    else
      f.frame_ctl = f.frame_ctl | FC_TYPE_MASK;
    f.addr1_multicast = ($urandom_range(0, 15) == 0);
    f.seq_control = seq_pool[$urandom_range(0, 3)];
    f.qos_tid = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(8, 15))
                                             : 4'($urandom_range(0, 3));
    extra = $urandom_range(0, 3);
    broken = ($urandom_range(0, 7) == 0);
    f.amsdu_flag = !broken && (extra > 0 || $urandom_range(0, 7) == 0);
    sub = 0;
    for (int i = 0; i <= int'(extra); i++) begin
      f.subframe_index = 7'(sub);
      subs.push_back(7'(sub));
      f.frame_ctl = ($urandom_range(0, 3) == 0) ? (f.frame_ctl | FC_RETRY)
                                                : (f.frame_ctl & ~FC_RETRY);
      send_desc(f, 1'b0, V_PASS);
      step = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 60) : 1;
      sub = (sub + step > 127) ? 127 : sub + step;
    end
    if ($urandom_range(0, 1) == 1) begin
      f.subframe_index = subs[$urandom_range(0, subs.size() - 1)];
      f.frame_ctl = f.frame_ctl | FC_RETRY;
      send_desc(f, 1'b0, V_PASS);
    end
  endtask

  task automatic send_noise();
    logic [63:0] raw;
    rdf_in_t     f;
    raw = {$urandom, $urandom};
    f = raw[$bits(rdf_in_t)-1:0];
    send_desc(f, 1'b0, V_PASS);
  endtask

  task automatic refresh_seq_pool();
    seq_pool[0] = 16'($urandom);
    seq_pool[1] = 16'($urandom);
    seq_pool[2] = SEQ_RESET;
    seq_pool[3] = ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'($urandom);
  endtask

  initial begin : table_reset
    for (int i = 0; i < ENTRIES; i++) begin
      seq_mem[i] = SEQ_RESET;
      sub_mem[i] = SUB_RESET;
    end
  end

  // The sink draws a stall before every transfer and then holds tready high.
  initial begin : sink
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = pick_wait(sink_burst);
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin : verdict_check
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with no descriptor pending, tdata", int'(m_axis_tdata), 0);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want.drop)
          report_mismatch("drop", int'(m_axis_tdata[0]), int'(want.drop));
        if (m_axis_tdata[1] !== want.allow_same_pn)
          report_mismatch("allow_same_pn", int'(m_axis_tdata[1]), int'(want.allow_same_pn));
        if (m_axis_tdata[2] !== want.dup_validated)
          report_mismatch("dup_validated", int'(m_axis_tdata[2]), int'(want.dup_validated));
        if (m_axis_tdata[OUT_DATA_W-1:3] !== '0)
          report_mismatch("zero fill", int'(m_axis_tdata[OUT_DATA_W-1:3]), 0);
        drops_seen   += int'(want.drop);
        same_pn_seen += int'(want.allow_same_pn);
        updates_seen += int'(want.dup_validated);
      end
    end
  end

  // The table sweep after reset keeps tready low; the
  // limit covers it with room to spare.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d verdicts outstanding",
                 STALL_LIMIT, verdict_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int directed_n;

    // No station, exempt frames and malformed descriptors.
    add_row(1'b0, 4'd15, 2'd3, FC_QOS_DATA, 1'b0, 16'h1234, 4'd0, 7'd0, 1'b0, 1'b1, V_PASS);
    add_row(1'b1, 4'd0, 2'd0, FC_CTL_ACK | FC_RETRY, 1'b0, 16'h0010, 4'd0, 7'd0, 1'b0,
            1'b1, V_PASS);
    add_row(1'b1, 4'd1, 2'd0, FC_QOS_DATA, 1'b1, 16'h0020, 4'd1, 7'd0, 1'b0, 1'b1, V_PASS);
    add_row(1'b1, 4'd1, 2'd1, FC_NULLFUNC, 1'b0, 16'h0030, 4'd0, 7'd0, 1'b0, 1'b1, V_PASS);
    add_row(1'b1, 4'd1, 2'd2, FC_QOS_NULLFUNC | FC_RETRY, 1'b0, 16'h0040, 4'd2, 7'd0, 1'b0,
            1'b1, V_PASS);
    add_row(1'b1, 4'd3, 2'd0, FC_QOS_DATA, 1'b0, 16'h0050, 4'd8, 7'd0, 1'b0, 1'b1, V_DROP);
    add_row(1'b1, 4'd3, 2'd0, FC_QOS_DATA, 1'b0, 16'h0050, 4'd15, 7'd0, 1'b1, 1'b1, V_DROP);
    add_row(1'b1, 4'd3, 2'd1, FC_TYPE_DATA, 1'b0, 16'h0060, 4'd0, 7'd127, 1'b0, 1'b1, V_DROP);
    // A real all-ones sequence number matches an entry never written.
    add_row(1'b1, 4'd15, 2'd3, FC_QOS_DATA | FC_RETRY, 1'b0, 16'hFFFF, 4'd7, 7'd0, 1'b0,
            1'b1, V_DROP);
    add_row(1'b1, 4'd15, 2'd3, FC_QOS_DATA, 1'b0, 16'hFFFF, 4'd7, 7'd0, 1'b0, 1'b1, V_NEW);
    // Fresh entry, then a retried duplicate and A-MSDU subframes of the same MSDU.
    add_row(1'b1, 4'd2, 2'd1, FC_QOS_DATA, 1'b0, 16'h0000, 4'd0, 7'd0, 1'b0, 1'b1, V_NEW);
    add_row(1'b1, 4'd2, 2'd1, FC_QOS_DATA | FC_RETRY, 1'b0, 16'h0000, 4'd0, 7'd0, 1'b0,
            1'b1, V_DROP);
    add_row(1'b1, 4'd2, 2'd1, FC_QOS_DATA | FC_RETRY, 1'b0, 16'h0000, 4'd0, 7'd1, 1'b1,
            1'b1, V_PN);
    add_row(1'b1, 4'd2, 2'd1, FC_QOS_DATA | FC_RETRY, 1'b0, 16'h0000, 4'd0, 7'd1, 1'b1,
            1'b1, V_DROP);
    add_row(1'b1, 4'd2, 2'd1, FC_QOS_DATA | FC_RETRY, 1'b0, 16'h0000, 4'd0, 7'd127, 1'b1,
            1'b1, V_PN);
    add_row(1'b1, 4'd2, 2'd1, FC_QOS_DATA, 1'b0, 16'hFFFE, 4'd0, 7'd0, 1'b1, 1'b0, V_PASS);
    // Non-QoS data and management frames share the non-QoS slot.
    add_row(1'b1, 4'd15, 2'd3, FC_TYPE_DATA | 16'hFF00, 1'b0, 16'h8001, 4'd15, 7'd0, 1'b0,
            1'b1, V_NEW);
    add_row(1'b1, 4'd15, 2'd3, FC_TYPE_DATA | 16'hFF00, 1'b0, 16'h8001, 4'd0, 7'd0, 1'b0,
            1'b1, V_DROP);
    add_row(1'b1, 4'd15, 2'd3, FC_MGMT_AUTH | FC_RETRY, 1'b0, 16'h8001, 4'd3, 7'd0, 1'b0,
            1'b1, V_DROP);
    add_row(1'b1, 4'd15, 2'd3, FC_MGMT_AUTH, 1'b0, 16'h8001, 4'd3, 7'd0, 1'b0, 1'b1, V_NEW);
    add_row(1'b1, 4'd9, 2'd2, FC_RESERVED_TYPE | 16'h00F3, 1'b0, 16'h7FFF, 4'd9, 7'd64, 1'b1,
            1'b0, V_PASS);
    add_row(1'b0, 4'd15, 2'd3, 16'hFFFF, 1'b1, 16'hFFFF, 4'd15, 7'd127, 1'b1, 1'b1, V_PASS);
    add_row(1'b1, 4'd0, 2'd0, FC_QOS_DATA, 1'b0, 16'h5A5A, 4'd0, 7'd0, 1'b1, 1'b0, V_PASS);

    refresh_seq_pool();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i])
      send_desc(dir_tab[i].desc, dir_tab[i].typed, dir_tab[i].want);
    directed_n = items_sent;

    while (items_sent < directed_n + RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        src_burst  = ($urandom_range(0, 2) == 0);
        sink_burst = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 15) == 0)
        refresh_seq_pool();
      if ($urandom_range(0, 4) == 0)
        send_noise();
      else
        send_run();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d descriptors (%0d from the directed table), checked %0d verdicts.",
             items_sent, directed_n, verdicts_seen);
    $display("Expected %0d drops, %0d same-PN subframes and %0d table updates; %0d errors.",
             drops_seen, same_pn_seen, updates_seen, errors);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
